/* hdl/wbss_pkg.sv */
// ----------------------------------------------------------------------------
// wbss_pkg: shared definitions for the wildcard byte signature scanner
// Operation codes, result codes, register indexes, field widths and the
// per-beat command strobes passed between the scanner modules.
// ----------------------------------------------------------------------------
package wbss_pkg;

    localparam int MAX_PATTERN_DEF = 64;
    localparam int ADDR_W          = 64;
    localparam int COUNT_W         = 5;
    localparam int CFG_INDEX_W     = 2;
    localparam int CFG_DATA_W      = 8;
    localparam int S_TDATA_W       = 88;
    localparam int M_TDATA_W       = 72;

    localparam logic [COUNT_W-1:0] MATCH_LIMIT = 5'd16;

    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_SPAN   = 2'd1;
    localparam logic [1:0] OP_SCAN   = 2'd2;
    localparam logic [1:0] OP_FINISH = 2'd3;

    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LENGTH = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_HOOK_ADD       = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_MATCHES    = 2'd2;

    localparam logic KIND_MATCH   = 1'b0;
    localparam logic KIND_OUTCOME = 1'b1;

    localparam logic [1:0] STATUS_NOT_FOUND = 2'd0;
    localparam logic [1:0] STATUS_UNIQUE    = 2'd1;
    localparam logic [1:0] STATUS_AMBIGUOUS = 2'd2;

    typedef struct packed {
        logic load;
        logic span;
        logic scan;
        logic finish;
    } cmd_t;

endpackage

/* hdl/wbss_pattern_table.sv */
// ----------------------------------------------------------------------------
// wbss_pattern_table: signature storage
// Holds the expected byte and the wildcard flag of every pattern position.
// All positions are presented in parallel to the window comparator.
// ----------------------------------------------------------------------------
module wbss_pattern_table
    import wbss_pkg::*;
#(
    parameter int MAX_PATTERN = MAX_PATTERN_DEF
) (
    input  logic       aclk,
    input  cmd_t       cmd,
    input  logic [5:0] pattern_index,
    input  logic [7:0] pattern_value,
    input  logic       pattern_wildcard,
    output logic [7:0] pat_value [MAX_PATTERN],
    output logic       pat_any   [MAX_PATTERN]
);

    logic [7:0] value_reg [MAX_PATTERN];
    logic       any_reg   [MAX_PATTERN];

    for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_entry
        always_ff @(posedge aclk) begin
            if (cmd.load && (32'(pattern_index) == k)) begin
                value_reg[k] <= pattern_value;
                any_reg[k]   <= pattern_wildcard;
            end
        end
        assign pat_value[k] = value_reg[k];
        assign pat_any[k]   = any_reg[k];
    end

endmodule

/* hdl/wbss_window.sv */
// ----------------------------------------------------------------------------
// wbss_window: sliding byte window and parallel compare
// Shifts each scanned byte into the window, tracks how many bytes the
// current span holds, and compares every pattern position in one pass.
// ----------------------------------------------------------------------------
module wbss_window
    import wbss_pkg::*;
#(
    parameter int MAX_PATTERN = MAX_PATTERN_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  cmd_t                               cmd,
    input  logic [7:0]                         data_byte,
    input  logic [$clog2(MAX_PATTERN+1)-1:0]   used_len,
    input  logic [7:0]                         pat_value [MAX_PATTERN],
    input  logic                               pat_any   [MAX_PATTERN],
    output logic                               hit
);

    localparam int LEN_W = $clog2(MAX_PATTERN + 1);

    logic [7:0]               win_reg  [MAX_PATTERN];
    logic [7:0]               win_next [MAX_PATTERN];
    logic [LEN_W-1:0]         fill_reg;
    logic [LEN_W-1:0]         fill_next;
    logic [LEN_W-1:0]         fill_inc;
    logic [LEN_W-1:0]         shamt;
    logic [MAX_PATTERN*8-1:0] rev_flat;
    logic [MAX_PATTERN*8-1:0] aligned_flat;
    logic [MAX_PATTERN-1:0]   pos_ok;

    always_comb begin
        win_next[0] = data_byte;
        for (int k = 1; k < MAX_PATTERN; k++) begin
            win_next[k] = win_reg[k-1];
        end
    end

    // The oldest byte goes to the lowest lane so that a right shift by the
    // unused depth lines up the window with pattern position zero.
    always_comb begin
        for (int k = 0; k < MAX_PATTERN; k++) begin
            rev_flat[k*8 +: 8] = win_next[MAX_PATTERN-1-k];
        end
    end

    assign shamt        = LEN_W'(MAX_PATTERN) - used_len;
    assign aligned_flat = rev_flat >> {shamt, 3'b000};

    always_comb begin
        for (int i = 0; i < MAX_PATTERN; i++) begin
            pos_ok[i] = (LEN_W'(i) >= used_len) || pat_any[i] ||
                        (aligned_flat[i*8 +: 8] == pat_value[i]);
        end
    end

    assign fill_inc = (fill_reg == LEN_W'(MAX_PATTERN)) ? fill_reg : fill_reg + 1'b1;

    always_comb begin
        priority if (cmd.span || cmd.finish) begin
            fill_next = '0;
        end else if (cmd.scan) begin
            fill_next = fill_inc;
        end else begin
            fill_next = fill_reg;
        end
    end

    assign hit = cmd.scan && (used_len != '0) && (fill_inc >= used_len) && (&pos_ok);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
        end else begin
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.scan) begin
            for (int k = 0; k < MAX_PATTERN; k++) begin
                win_reg[k] <= win_next[k];
            end
        end
    end

endmodule

/* hdl/wbss_outcome.sv */
// ----------------------------------------------------------------------------
// wbss_outcome: match counting and result register
// Counts matches up to the limit, keeps the first match address, and
// holds the next result beat until the downstream side takes it.
// ----------------------------------------------------------------------------
module wbss_outcome
    import wbss_pkg::*;
#(
    parameter int MAX_PATTERN = MAX_PATTERN_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  cmd_t                             cmd,
    input  logic                             hit,
    input  logic [ADDR_W-1:0]                byte_address,
    input  logic [$clog2(MAX_PATTERN+1)-1:0] used_len,
    input  logic [7:0]                       hook_add,
    input  logic [COUNT_W-1:0]               used_limit,
    input  logic                             res_ready,
    output logic                             res_valid,
    output logic                             res_kind,
    output logic [ADDR_W-1:0]                res_address,
    output logic [1:0]                       res_status,
    output logic [COUNT_W-1:0]               res_count
);

    logic [COUNT_W-1:0] found_count_reg, found_count_next;
    logic [ADDR_W-1:0]  first_addr_reg, first_addr_next;
    logic [ADDR_W-1:0]  start_addr;
    logic               emit;
    logic               kind_next;
    logic [ADDR_W-1:0]  address_next;
    logic [1:0]         status_next;
    logic [COUNT_W-1:0] count_next;
    logic               valid_reg;
    logic               kind_reg;
    logic [ADDR_W-1:0]  address_reg;
    logic [1:0]         status_reg;
    logic [COUNT_W-1:0] count_reg;

    assign start_addr = byte_address - ADDR_W'(used_len) + 64'd1;

    always_comb begin
        found_count_next = found_count_reg;
        first_addr_next  = first_addr_reg;
        emit             = 1'b0;
        kind_next        = KIND_MATCH;
        address_next     = '0;
        status_next      = STATUS_NOT_FOUND;
        count_next       = found_count_reg;
        priority if (cmd.finish) begin
            emit             = 1'b1;
            kind_next        = KIND_OUTCOME;
            found_count_next = '0;
            first_addr_next  = '0;
            priority if (found_count_reg == '0) begin
                status_next = STATUS_NOT_FOUND;
            end else if (found_count_reg == 5'd1) begin
                status_next  = STATUS_UNIQUE;
                address_next = first_addr_reg + ADDR_W'(hook_add);
            end else begin
                status_next = STATUS_AMBIGUOUS;
            end
        end else if (hit && (found_count_reg < used_limit)) begin
            emit             = 1'b1;
            found_count_next = found_count_reg + 1'b1;
            if (found_count_reg == '0) begin
                first_addr_next = start_addr;
            end
            address_next = start_addr;
            count_next   = found_count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            found_count_reg <= '0;
            first_addr_reg  <= '0;
            valid_reg       <= 1'b0;
        end else begin
            found_count_reg <= found_count_next;
            first_addr_reg  <= first_addr_next;
            if (emit) begin
                valid_reg <= 1'b1;
            end else if (res_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            kind_reg    <= kind_next;
            address_reg <= address_next;
            status_reg  <= status_next;
            count_reg   <= count_next;
        end
    end

    assign res_valid   = valid_reg;
    assign res_kind    = kind_reg;
    assign res_address = address_reg;
    assign res_status  = status_reg;
    assign res_count   = count_reg;

    a_count_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        found_count_reg <= MATCH_LIMIT)
        else $error("match count above the hard limit");

    a_finish_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |=> (found_count_reg == '0) && (first_addr_reg == '0))
        else $error("scan state not cleared after finish");

    a_report_counted: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && (kind_reg == KIND_MATCH)) |-> (count_reg != '0))
        else $error("match report with zero count");

    a_unique_single: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && (kind_reg == KIND_OUTCOME) && (status_reg == STATUS_UNIQUE))
            |-> (count_reg == 5'd1))
        else $error("unique outcome without exactly one match");

endmodule

/* hdl/wildcard_byte_signature_scanner.sv */
// ----------------------------------------------------------------------------
// wildcard_byte_signature_scanner: wildcard byte signature scanner
// A result beat is registered and appears in the cycle after its input beat is accepted.
// Throughput: one input beat per cycle while no result beat waits; all pattern positions compare in one pass.
// A result beat that waits holds s_tready low until m_tready takes it.
// Reset clears the window fill, match count, first address, output valid and
// the registers to length 1, hook offset 0, limit 16; the pattern is not cleared.
// ----------------------------------------------------------------------------
module wildcard_byte_signature_scanner
    import wbss_pkg::*;
#(
    parameter int MAX_PATTERN = MAX_PATTERN_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // pattern_index[5:0], pattern_value[13:6], pattern_wildcard[14],
    // data_byte[22:15], byte_address[86:23], zero pad[87]
    input  logic [S_TDATA_W-1:0]   s_tdata,
    // operation[1:0]
    input  logic [1:0]             s_tuser,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // address[63:0], status[65:64], match_count[70:66], zero pad[71]
    output logic [M_TDATA_W-1:0]   m_tdata,
    // result_kind[0]
    output logic                   m_tuser
);

    localparam int LEN_W = $clog2(MAX_PATTERN + 1);

    logic [6:0]         length_reg;
    logic [7:0]         hook_reg;
    logic [4:0]         max_matches_reg;
    logic [LEN_W-1:0]   used_len;
    logic [COUNT_W-1:0] used_limit;
    logic               accept;
    cmd_t               cmd;
    logic [7:0]         pat_value [MAX_PATTERN];
    logic               pat_any   [MAX_PATTERN];
    logic               hit;
    logic               res_kind;
    logic [ADDR_W-1:0]  res_address;
    logic [1:0]         res_status;
    logic [COUNT_W-1:0] res_count;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            length_reg      <= 7'd1;
            hook_reg        <= 8'd0;
            max_matches_reg <= MATCH_LIMIT;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_PATTERN_LENGTH: length_reg      <= cfg_wdata[6:0];
                REG_HOOK_ADD:       hook_reg        <= cfg_wdata;
                REG_MAX_MATCHES:    max_matches_reg <= cfg_wdata[4:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (32'(length_reg) > MAX_PATTERN) begin
            used_len = LEN_W'(MAX_PATTERN);
        end else begin
            used_len = LEN_W'(length_reg);
        end
    end

    always_comb begin
        priority if (max_matches_reg == '0) begin
            used_limit = 5'd1;
        end else if (max_matches_reg > MATCH_LIMIT) begin
            used_limit = MATCH_LIMIT;
        end else begin
            used_limit = max_matches_reg;
        end
    end

    assign s_tready = !m_tvalid || m_tready;
    assign accept   = s_tvalid && s_tready;

    assign cmd.load   = accept && (s_tuser == OP_LOAD);
    assign cmd.span   = accept && (s_tuser == OP_SPAN);
    assign cmd.scan   = accept && (s_tuser == OP_SCAN);
    assign cmd.finish = accept && (s_tuser == OP_FINISH);

    wbss_pattern_table #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_pattern (
        .aclk             (aclk),
        .cmd              (cmd),
        .pattern_index    (s_tdata[5:0]),
        .pattern_value    (s_tdata[13:6]),
        .pattern_wildcard (s_tdata[14]),
        .pat_value        (pat_value),
        .pat_any          (pat_any)
    );

    wbss_window #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_window (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .data_byte (s_tdata[22:15]),
        .used_len  (used_len),
        .pat_value (pat_value),
        .pat_any   (pat_any),
        .hit       (hit)
    );

    wbss_outcome #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_outcome (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .hit          (hit),
        .byte_address (s_tdata[86:23]),
        .used_len     (used_len),
        .hook_add     (hook_reg),
        .used_limit   (used_limit),
        .res_ready    (m_tready),
        .res_valid    (m_tvalid),
        .res_kind     (res_kind),
        .res_address  (res_address),
        .res_status   (res_status),
        .res_count    (res_count)
    );

    assign m_tdata = {1'b0, res_count, res_status, res_address};
    assign m_tuser = res_kind;

endmodule

/* tb/sv/wildcard_byte_signature_scanner_test.sv */
// ----------------------------------------------------------------------------
// Testbench for the wildcard byte signature scanner
// A short table of directed beats is sent first: outcomes after reset, address
// wrap, the length and limit corner settings, and wildcard positions. Then
// several register settings are used in turn. Each one loads a pattern and
// scans spans that hold embedded, spoiled and cut-off copies of it among
// random bytes. Each result beat is compared with the beat given in the table
// or else with one from a model of the scanner kept in this file.
// ----------------------------------------------------------------------------
module wildcard_byte_signature_scanner_test;
    import wbss_pkg::*;

    typedef struct packed {
        logic        kind;
        logic [63:0] addr;
        logic [1:0]  status;
        logic [4:0]  count;
    } scan_result_t;

    typedef enum logic [1:0] {ROW_MODEL, ROW_GIVEN, ROW_SILENT, ROW_CFG} row_kind_t;

    // In a register row the index travels in idx and the value in val.
    typedef struct packed {
        row_kind_t    kind;
        logic [1:0]   op;
        logic [5:0]   idx;
        logic [7:0]   val;
        logic         wild;
        logic [7:0]   data;
        logic [63:0]  addr;
        scan_result_t res;
    } table_row_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata = '0;
    logic [1:0]             s_tuser = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   m_tuser;

    logic [7:0]  recent_bytes [MAX_PATTERN_DEF] = '{default: '0};
    logic [7:0]  sig_byte [MAX_PATTERN_DEF] = '{default: '0};
    logic        sig_any [MAX_PATTERN_DEF] = '{default: '0};
    int          span_fill = 0;
    int          hits = 0;
    logic [63:0] first_hit_addr = '0;
    logic [6:0]  cfg_len = 7'd1;
    logic [7:0]  cfg_hook = 8'd0;
    logic [4:0]  cfg_max = 5'd16;

    scan_result_t reports_due [$];
    table_row_t   directed [$];
    int           beats_sent = 0;
    int           mismatches = 0;
    int           send_gap_pct = 8;
    int           recv_stall_pct = 71;

    wildcard_byte_signature_scanner dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #2 aclk = ~aclk;

    initial begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

    function automatic table_row_t beat(input logic [1:0] op, input logic [5:0] idx,
                                        input logic [7:0] val, input logic wild,
                                        input logic [7:0] data, input logic [63:0] addr);
        table_row_t r;
        r.kind = ROW_MODEL;
        r.op   = op;
        r.idx  = idx;
        r.val  = val;
        r.wild = wild;
        r.data = data;
        r.addr = addr;
        r.res  = '0;
        return r;
    endfunction

    function automatic table_row_t answer(input table_row_t r, input logic kind,
                                          input logic [63:0] addr, input logic [1:0] status,
                                          input logic [4:0] count);
        r.kind = ROW_GIVEN;
        r.res  = {kind, addr, status, count};
        return r;
    endfunction

    function automatic table_row_t silent(input table_row_t r);
        r.kind = ROW_SILENT;
        return r;
    endfunction

    function automatic table_row_t setting(input logic [1:0] index, input logic [7:0] value);
        table_row_t r;
        r = beat(OP_LOAD, 6'(index), value, 1'b0, 8'h00, 64'h0);
        r.kind = ROW_CFG;
        return r;
    endfunction

    function automatic void add_row(input table_row_t r);
        directed.insert(directed.size(), r);
    endfunction

    function automatic bit signature_step(input table_row_t r, output scan_result_t res);
        int used;
        int limit;
        bit hit;
        res = '0;
        case (r.op)
            OP_LOAD: begin
                sig_byte[r.idx] = r.val;
                sig_any[r.idx] = r.wild;
                return 1'b0;
            end
            OP_SPAN: begin
                span_fill = 0;
                return 1'b0;
            end
            OP_SCAN: begin
                for (int k = MAX_PATTERN_DEF - 1; k > 0; k--)
                    recent_bytes[k] = recent_bytes[k-1];
                recent_bytes[0] = r.data;
                if (span_fill < MAX_PATTERN_DEF)
                    span_fill++;
                used = (cfg_len > MAX_PATTERN_DEF) ? MAX_PATTERN_DEF : int'(cfg_len);
                limit = (cfg_max == 0) ? 1 : (cfg_max > MATCH_LIMIT) ? int'(MATCH_LIMIT)
                                                                     : int'(cfg_max);
                if (used == 0 || span_fill < used || hits >= limit)
                    return 1'b0;
                hit = 1'b1;
                for (int i = 0; i < used; i++) begin
                    if (!sig_any[i] && recent_bytes[used-1-i] != sig_byte[i])
                        hit = 1'b0;
                end
                if (!hit)
                    return 1'b0;
                res.kind = KIND_MATCH;
                res.addr = r.addr - 64'(used - 1);
                res.status = STATUS_NOT_FOUND;
                if (hits == 0)
                    first_hit_addr = res.addr;
                hits++;
                res.count = 5'(hits);
                return 1'b1;
            end
            default: begin
                res.kind = KIND_OUTCOME;
                if (hits == 0) begin
                    res.status = STATUS_NOT_FOUND;
                end else if (hits == 1) begin
                    res.addr = first_hit_addr + 64'(cfg_hook);
                    res.status = STATUS_UNIQUE;
                end else begin
                    res.status = STATUS_AMBIGUOUS;
                end
                res.count = 5'(hits);
                hits = 0;
                first_hit_addr = '0;
                span_fill = 0;
                return 1'b1;
            end
        endcase
    endfunction

    task automatic send_beat(input table_row_t r);
        scan_result_t res;
        bit produced;
        while ($urandom_range(99) < send_gap_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= r.op;
        s_tdata <= {1'b0, r.addr, r.data, r.wild, r.val, r.idx};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        produced = signature_step(r, res);
        if (r.kind == ROW_GIVEN) begin
            produced = 1'b1;
            res = r.res;
        end else if (r.kind == ROW_SILENT) begin
            produced = 1'b0;
        end
        if (produced)
            reports_due.insert(reports_due.size(), res);
        beats_sent++;
        @(negedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] index, input logic [7:0] value);
        s_tvalid <= 1'b0;
        while (reports_due.size() != 0)
            @(negedge aclk);
        repeat (3) @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        case (index)
            REG_PATTERN_LENGTH: cfg_len = value[6:0];
            REG_HOOK_ADD:       cfg_hook = value;
            REG_MAX_MATCHES:    cfg_max = value[4:0];
            default: ;
        endcase
        @(negedge aclk);
    endtask

    task automatic scan_phase(input logic [7:0] len_w, input logic [7:0] hook_w,
                              input logic [7:0] max_w, input int budget, input bit load_all);
        int used;
        int stop;
        int pick;
        int spoil;
        int n;
        logic [63:0] a;
        logic [7:0] b;
        write_reg(REG_PATTERN_LENGTH, len_w);
        write_reg(REG_HOOK_ADD, hook_w);
        write_reg(REG_MAX_MATCHES, max_w);
        used = (cfg_len > MAX_PATTERN_DEF) ? MAX_PATTERN_DEF : int'(cfg_len);
        for (int i = 0; i < (load_all ? MAX_PATTERN_DEF : used); i++)
            send_beat(beat(OP_LOAD, 6'(i), 8'($urandom), $urandom_range(3) == 0,
                           8'($urandom), {$urandom, $urandom}));
        stop = beats_sent + budget;
        while (beats_sent < stop) begin
            send_beat(beat(OP_SPAN, 6'($urandom), 8'($urandom), 1'($urandom), 8'($urandom),
                           {$urandom, $urandom}));
            pick = $urandom_range(3);
            a = {$urandom, $urandom};
            if (pick == 0)
                a = ~64'($urandom_range(40));
            else if (pick == 1)
                a = 64'($urandom_range(40));
            repeat ($urandom_range(1, 4)) begin
                repeat ($urandom_range(6)) begin
                    send_beat(beat(OP_SCAN, 6'h00, 8'h00, 1'b0, 8'($urandom), a));
                    a++;
                end
                if ($urandom_range(7) == 0)
                    send_beat(beat(OP_LOAD, 6'($urandom), 8'($urandom), 1'($urandom),
                                   8'h00, 64'h0));
                if ($urandom_range(9) != 0) begin
                    spoil = $urandom_range(7);
                    n = $urandom_range(used);
                    for (int i = 0; i < used; i++) begin
                        if (spoil == 1 && i == n)
                            send_beat(beat(OP_SPAN, 6'h00, 8'h00, 1'b0, 8'h00, 64'h0));
                        b = sig_any[i] ? 8'($urandom) : sig_byte[i];
                        if (spoil == 0 && i == n)
                            b = ~b;
                        send_beat(beat(OP_SCAN, 6'h00, 8'h00, 1'b0, b, a));
                        a++;
                    end
                end
            end
            if ($urandom_range(2) == 0)
                send_beat(beat(OP_FINISH, 6'h00, 8'h00, 1'b0, 8'h00, 64'h0));
        end
        send_beat(beat(OP_FINISH, 6'h00, 8'h00, 1'b0, 8'h00, 64'h0));
    endtask

    always @(negedge aclk)
        m_tready <= ($urandom_range(99) >= recv_stall_pct);

    always @(posedge aclk) begin : result_check
        scan_result_t got;
        scan_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tuser, m_tdata[63:0], m_tdata[65:64], m_tdata[70:66]};
            if (reports_due.size() == 0) begin
                $error("result beat with nothing outstanding: kind %0h address %0h",
                       got.kind, got.addr);
                mismatches++;
            end else begin
                want = reports_due.pop_front();
                if (got.kind !== want.kind) begin
                    $error("result_kind expected %0h actual %0h", want.kind, got.kind);
                    mismatches++;
                end
                if (got.addr !== want.addr) begin
                    $error("address expected %0h actual %0h", want.addr, got.addr);
                    mismatches++;
                end
                if (got.status !== want.status) begin
                    $error("status expected %0h actual %0h", want.status, got.status);
                    mismatches++;
                end
                if (got.count !== want.count) begin
                    $error("match_count expected %0h actual %0h", want.count, got.count);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        add_row(answer(beat(OP_FINISH, 0, 0, 0, 0, 0),
                       KIND_OUTCOME, 64'h0, STATUS_NOT_FOUND, 5'd0));
        add_row(beat(OP_LOAD, 6'd0, 8'hFF, 1'b0, 8'h00, 64'h0));
        add_row(beat(OP_LOAD, 6'd63, 8'h00, 1'b1, 8'h00, 64'h0));
        add_row(beat(OP_SPAN, 0, 0, 0, 0, 0));
        add_row(answer(beat(OP_SCAN, 0, 0, 0, 8'hFF, 64'h0),
                       KIND_MATCH, 64'h0, STATUS_NOT_FOUND, 5'd1));
        add_row(silent(beat(OP_SCAN, 0, 0, 0, 8'h00, 64'h1)));
        add_row(answer(beat(OP_FINISH, 0, 0, 0, 0, 0),
                       KIND_OUTCOME, 64'h0, STATUS_UNIQUE, 5'd1));
        add_row(answer(beat(OP_SCAN, 0, 0, 0, 8'hFF, 64'hFFFF_FFFF_FFFF_FFFF),
                       KIND_MATCH, 64'hFFFF_FFFF_FFFF_FFFF, STATUS_NOT_FOUND, 5'd1));
        add_row(answer(beat(OP_SCAN, 0, 0, 0, 8'hFF, 64'h5),
                       KIND_MATCH, 64'h5, STATUS_NOT_FOUND, 5'd2));
        add_row(answer(beat(OP_FINISH, 0, 0, 0, 0, 0),
                       KIND_OUTCOME, 64'h0, STATUS_AMBIGUOUS, 5'd2));
        add_row(setting(REG_HOOK_ADD, 8'd255));
        add_row(beat(OP_SCAN, 0, 0, 0, 8'hFF, 64'hFFFF_FFFF_FFFF_FF80));
        add_row(answer(beat(OP_FINISH, 0, 0, 0, 0, 0),
                       KIND_OUTCOME, 64'h7F, STATUS_UNIQUE, 5'd1));
        add_row(setting(REG_PATTERN_LENGTH, 8'd0));
        add_row(silent(beat(OP_SCAN, 0, 0, 0, 8'hFF, 64'h1)));
        add_row(answer(beat(OP_FINISH, 0, 0, 0, 0, 0),
                       KIND_OUTCOME, 64'h0, STATUS_NOT_FOUND, 5'd0));
        add_row(setting(REG_PATTERN_LENGTH, 8'd2));
        add_row(setting(REG_MAX_MATCHES, 8'd0));
        add_row(beat(OP_LOAD, 6'd1, 8'hAB, 1'b0, 8'h00, 64'h0));
        add_row(beat(OP_SCAN, 0, 0, 0, 8'hFF, 64'hFFFF_FFFF_FFFF_FFFF));
        add_row(beat(OP_SCAN, 0, 0, 0, 8'hAB, 64'h0));
        add_row(beat(OP_SCAN, 0, 0, 0, 8'hFF, 64'h7));
        add_row(beat(OP_SCAN, 0, 0, 0, 8'hAB, 64'h8));
        add_row(beat(OP_FINISH, 0, 0, 0, 0, 0));
        add_row(beat(OP_LOAD, 6'd0, 8'h00, 1'b1, 8'h00, 64'h0));
        add_row(beat(OP_SPAN, 0, 0, 0, 0, 0));
        add_row(beat(OP_SCAN, 0, 0, 0, 8'h5A, 64'h20));
        add_row(beat(OP_SCAN, 0, 0, 0, 8'hAB, 64'h21));
        add_row(beat(OP_FINISH, 0, 0, 0, 0, 0));

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (directed[i]) begin
            if (directed[i].kind == ROW_CFG)
                write_reg(directed[i].idx[1:0], directed[i].val);
            else
                send_beat(directed[i]);
        end

        scan_phase(8'd3, 8'($urandom), 8'd16, 15, 1'b1);
        scan_phase(8'd1, 8'd0, 8'd1, 15, 1'b0);
        scan_phase(8'd64, 8'd255, 8'd16, 1, 1'b0);
        send_gap_pct = 71;
        recv_stall_pct = 8;
        scan_phase(8'd127, 8'($urandom), 8'd31, 1, 1'b0);
        scan_phase(8'($urandom_range(1, 8)), 8'($urandom), 8'($urandom_range(1, 16)), 15, 1'b0);
        scan_phase(8'($urandom_range(2, 20)), 8'($urandom), 8'd0, 15, 1'b0);
        send_gap_pct = 0;
        recv_stall_pct = 0;
        scan_phase(8'($urandom_range(1, 32)), 8'($urandom), 8'($urandom_range(31)), 15, 1'b0);
        scan_phase(8'd2, 8'($urandom), 8'd16, 15, 1'b0);
        scan_phase(8'($urandom_range(1, 6)), 8'd255, 8'($urandom_range(1, 16)), 15, 1'b0);

        s_tvalid <= 1'b0;
        while (reports_due.size() != 0)
            @(negedge aclk);
        repeat (8) @(negedge aclk);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule

/* filelist.f */
hdl/wbss_pkg.sv
hdl/wbss_pattern_table.sv
hdl/wbss_window.sv
hdl/wbss_outcome.sv
hdl/wildcard_byte_signature_scanner.sv
tb/sv/wildcard_byte_signature_scanner_test.sv
